[hdl/reference_count_table_macros.svh]
// ----------------------------------------------------------------------------
// Reference count table assertion macros
// Shared concurrent assertion forms used by the table's RTL.
// ----------------------------------------------------------------------------
`ifndef REFERENCE_COUNT_TABLE_MACROS_SVH
`define REFERENCE_COUNT_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rct_pkg.sv]
// ----------------------------------------------------------------------------
// Reference count table package
// Sizes, codes and the structs passed between the table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 32;
  localparam int KEY_BITS   = 64;
  localparam int AMT_BITS   = 32;
  localparam int OUT_BITS   = 32;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [AMT_BITS-1:0]   amount_t;
  typedef logic [2:0]            status_t;

  localparam count_t COUNT_MAX = '1;

  // Command codes.
  localparam logic CMD_INC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // Result status codes.
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NOTFOUND = 3'd1;
  localparam status_t ST_CLAMPED  = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_SAT      = 3'd4;

  // Update of the key store: set places a key and marks the slot valid,
  // clr frees the slot.
  typedef struct packed {
    logic set;
    logic clr;
    idx_t idx;
    key_t key;
  } tbl_wr_t;

  // Outcome of a key search.
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free;
    idx_t free_idx;
  } tbl_res_t;

  // Low output bits of a count, zero extended when the count is narrower.
  function automatic logic [OUT_BITS-1:0] count_out(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/rct_keystore.sv]
// ----------------------------------------------------------------------------
// Reference count table key store
// Holds the slot keys and valid bits and searches them for a key and for
// the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rct_keystore (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rct_pkg::key_t    key,
  input  wire rct_pkg::tbl_wr_t wr,
  output rct_pkg::tbl_res_t     res
);
  import rct_pkg::*;

  key_t               keys  [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.set) begin
      valid[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      valid[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      keys[wr.idx] <= wr.key;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == key);
    end
  end

  // Lowest index wins in both searches.
  always_comb begin
    res = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        res.hit     = 1'b1;
        res.hit_idx = IDX_BITS'(i);
      end
      if (!valid[i]) begin
        res.free     = 1'b1;
        res.free_idx = IDX_BITS'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/reference_count_table.sv]
// ----------------------------------------------------------------------------
// Reference count table
// Bounded associative table from a 64-bit key to a saturating use count,
// with increment, decrement, insertion on first use and removal at zero.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                 Handshake
//   -------   -------------------------------------   -------------------------
//   command   cmd, key, amount                        taken when start && !busy
//   result    status, count_after, entry_removed      one cycle, marked by done
//
// An item passes through a lookup cycle, in which the key is compared
// against every stored key and the count memory is read, then an update
// cycle, in which the count is modified and written back. The memory's
// registered read sets that order. busy is high only in the lookup cycle,
// so a new item is taken in the update cycle of the one before. The result
// appears the cycle after the update and is held; done is not.
// Reset is synchronous and frees every slot at once through the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reference_count_table_macros.svh"

module reference_count_table (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     cmd,
  input  wire rct_pkg::key_t            key,
  input  wire rct_pkg::amount_t         amount,
  output logic                          done,
  output rct_pkg::status_t              status,
  output logic [rct_pkg::OUT_BITS-1:0]  count_after,
  output logic                          entry_removed
);
  import rct_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // Captured command.
  logic    cmd_q;
  key_t    key_q;
  amount_t amount_q;

  // Search outcome and count read, both valid in the update cycle.
  tbl_res_t look;
  tbl_res_t look_q;
  count_t   rd_data;

  // Count memory; it is read at the hit index even when no slot matched.
  count_t count_mem [ENTRIES];

  // Update-cycle decisions.
  tbl_wr_t wr;
  logic    mem_we;
  idx_t    mem_addr;
  count_t  new_count;
  status_t res_status;
  count_t  res_count;
  logic    res_removed;

  assign busy   = (state == S_LOOKUP);
  assign accept = start && !busy;

  rct_keystore u_keystore (
    .clk (clk),
    .rst (rst),
    .key (key_q),
    .wr  (wr),
    .res (look)
  );

  always_comb begin
    case (state)
      S_IDLE:   state_next = accept ? S_LOOKUP : S_IDLE;
      S_LOOKUP: state_next = S_UPDATE;
      S_UPDATE: state_next = accept ? S_LOOKUP : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd;
      key_q    <= key;
      amount_q <= amount;
    end
    if (state == S_LOOKUP) begin
      look_q <= look;
    end
  end

  // The read in the lookup cycle always sees the previous item's write,
  // which completed at the end of its update cycle.
  always_ff @(posedge clk) begin
    if (state == S_LOOKUP) begin
      rd_data <= count_mem[look.hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_addr] <= new_count;
    end
  end

  // Read-modify-write of the count for the item in its update cycle.
  always_comb begin
    wr          = '0;
    wr.key      = key_q;
    wr.idx      = look_q.hit_idx;
    mem_we      = 1'b0;
    mem_addr    = look_q.hit_idx;
    new_count   = rd_data;
    res_status  = ST_OK;
    res_count   = '0;
    res_removed = 1'b0;
    if (state == S_UPDATE) begin
      if (cmd_q == CMD_INC) begin
        if (look_q.hit) begin
          if (rd_data == COUNT_MAX) begin
            res_status = ST_SAT;
            new_count  = COUNT_MAX;
          end else begin
            new_count = rd_data + COUNT_BITS'(1);
          end
          mem_we    = 1'b1;
          res_count = new_count;
        end else if (look_q.free) begin
          // First use of the key: claim the lowest free slot.
          wr.set    = 1'b1;
          wr.idx    = look_q.free_idx;
          mem_addr  = look_q.free_idx;
          new_count = COUNT_BITS'(1);
          mem_we    = 1'b1;
          res_count = new_count;
        end else begin
          res_status = ST_FULL;
        end
      end else begin
        if (!look_q.hit) begin
          res_status = ST_NOTFOUND;
        end else begin
          if (64'(amount_q) > 64'(rd_data)) begin
            // Too large an amount is clamped, which drains the entry.
            res_status = ST_CLAMPED;
            new_count  = '0;
          end else begin
            new_count = rd_data - COUNT_BITS'(amount_q);
          end
          mem_we    = 1'b1;
          res_count = new_count;
          if (new_count == '0) begin
            wr.clr      = 1'b1;
            res_removed = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      status        <= res_status;
      count_after   <= count_out(res_count);
      entry_removed <= res_removed;
    end
  end

  `RCT_ASSERT_NEXT(a_take_lookup, clk, rst, accept, state == S_LOOKUP, "item not looked up")
  `RCT_ASSERT_NEXT(a_done_after_update, clk, rst, state == S_UPDATE, done, "result missing")
  `RCT_ASSERT_NEXT(a_no_stray_done, clk, rst, state != S_UPDATE, !done, "stray result")
  `RCT_ASSERT_NOW(a_removed_zero, clk, rst, done && entry_removed, count_after == '0, "removed nonzero")
  `RCT_ASSERT_NOW(a_full_zero, clk, rst, done && (status == ST_FULL), count_after == '0, "full nonzero")

endmodule

`default_nettype wire
